### rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared assertion macros for the depth sorter RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("implication check failed");

// Next-cycle implication, checked out of reset.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

// Invariant, checked out of reset.
`define ASSERT_ALWAYS(label, clk, rst, cond) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error("invariant check failed");

`endif

### rtl/vods_pkg.sv
// ----------------------------------------------------------------------------
// vods_pkg
// Types and constants shared by the visible object depth sorter.
// ----------------------------------------------------------------------------
package vods_pkg;

  localparam int MAX_OBJECTS = 32;  // insertion chain length (2..64)

  localparam int ID_W   = 16;
  localparam int KEY_W  = 16;
  localparam int COORD_W = 16;
  localparam int SCR_W  = 12;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_DATA_W = 12;

  localparam logic [SCR_W-1:0] SCREEN_WIDTH_RST  = 12'd800;
  localparam logic [SCR_W-1:0] SCREEN_HEIGHT_RST = 12'd600;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_SCREEN_WIDTH  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SCREEN_HEIGHT = 1'd1;

  typedef struct packed {
    logic            valid;
    logic [ID_W-1:0]  id;
    logic [KEY_W-1:0] key;  // two's complement
  } entry_t;

  // Per-cycle command broadcast to every cell
  typedef struct packed {
    logic insert;  // place the broadcast request in the chain
    logic shift;   // move every entry one cell toward the head
  } cell_ctl_t;

  typedef enum logic {
    ST_LOAD,
    ST_DRAIN
  } state_t;

endpackage

### rtl/vods_if.sv
// ----------------------------------------------------------------------------
// vods_if
// Valid/ready channels of the depth sorter: object requests and results.
// ----------------------------------------------------------------------------
interface vods_obj_if;
  logic                            valid;
  logic                            ready;
  logic [vods_pkg::ID_W-1:0]       object_id;
  logic signed [vods_pkg::KEY_W-1:0]   sort_key;
  logic signed [vods_pkg::COORD_W-1:0] rect_left;
  logic signed [vods_pkg::COORD_W-1:0] rect_right;
  logic signed [vods_pkg::COORD_W-1:0] rect_top;
  logic signed [vods_pkg::COORD_W-1:0] rect_bottom;
  logic                            frame_end;

  modport source (output valid, object_id, sort_key, rect_left, rect_right,
                  rect_top, rect_bottom, frame_end, input ready);
  modport sink   (input valid, object_id, sort_key, rect_left, rect_right,
                  rect_top, rect_bottom, frame_end, output ready);
endinterface

interface vods_res_if;
  logic                            valid;
  logic                            ready;
  logic [vods_pkg::ID_W-1:0]       out_object_id;
  logic signed [vods_pkg::KEY_W-1:0] out_sort_key;
  logic                            out_last;
  logic                            overflowed;

  modport source (output valid, out_object_id, out_sort_key, out_last, overflowed,
                  input ready);
  modport sink   (input valid, out_object_id, out_sort_key, out_last, overflowed,
                  output ready);
endinterface

### rtl/vods_cell.sv
// ----------------------------------------------------------------------------
// vods_cell
// One slot of the insertion chain: holds an entry, compares it to the
// broadcast key and takes its left or right neighbor's entry on demand.
// ----------------------------------------------------------------------------
module vods_cell (
  input  logic                       clk,
  input  logic                       rst,
  input  vods_pkg::cell_ctl_t        ctl,
  input  logic [vods_pkg::ID_W-1:0]  new_id,
  input  logic [vods_pkg::KEY_W-1:0] new_key,
  input  vods_pkg::entry_t           prev_entry,  // toward the head
  input  logic                       prev_gt,
  input  vods_pkg::entry_t           next_entry,  // toward the tail
  output vods_pkg::entry_t           entry,
  output logic                       gt
);

  vods_pkg::entry_t entry_next;
  vods_pkg::entry_t new_entry;

  // strict compare keeps equal keys in arrival order
  assign gt = entry.valid && ($signed(entry.key) > $signed(new_key));

  always_comb begin
    new_entry  = '{valid: 1'b1, id: new_id, key: new_key};
    entry_next = entry;
    if (ctl.shift) begin
      entry_next = next_entry;
    end else if (ctl.insert) begin
      if (prev_gt) begin
        entry_next = prev_entry;
      end else if (gt || (!entry.valid && prev_entry.valid)) begin
        entry_next = new_entry;
      end
    end
  end

  // only the valid bit needs a reset value
  always_ff @(posedge clk) begin
    if (rst) begin
      entry.valid <= 1'b0;
    end else begin
      entry <= entry_next;
    end
  end

endmodule

### rtl/visible_object_depth_sorter.sv
// ----------------------------------------------------------------------------
// visible_object_depth_sorter
// Screen cull plus systolic insertion sort of object ids by vertical key.
// ----------------------------------------------------------------------------
// Each object request is tested against the screen rectangle and, if it
// overlaps, dropped into a chain of MAX_OBJECTS cells that always holds the
// kept objects in ascending key order (ties in arrival order). Loading runs at
// one request per clock: the broadcast key is compared in every cell at once
// and the chain opens the gap on the edge that accepts the request. A request
// with frame_end set is placed first, then the chain drains from its head, one
// result per accepted result handshake, each cell handing its entry toward the
// head. No request is taken while draining, so a frame end holds off requests
// until every kept object has gone out and the sequencer is back in loading.
// Objects beyond capacity are dropped and every result of that frame reports
// overflowed. A frame with no kept objects produces no results. No clearing
// pass follows reset; the valid bit of each cell is cleared at once.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module visible_object_depth_sorter (
  input  logic                                clk,
  input  logic                                rst,
  vods_obj_if.sink                            objects,
  vods_res_if.source                          results,
  input  logic                                cfg_we,
  input  logic [vods_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [vods_pkg::CFG_DATA_W-1:0]     cfg_data
);

  localparam int N = vods_pkg::MAX_OBJECTS;

  vods_pkg::state_t    state, state_next;
  vods_pkg::cell_ctl_t ctl;
  logic [vods_pkg::SCR_W-1:0] screen_width, screen_height;
  logic dropped, dropped_next;

  vods_pkg::entry_t entries    [N];
  vods_pkg::entry_t prev_entry [N];
  vods_pkg::entry_t next_entry [N];
  logic             gt         [N];
  logic             prev_gt    [N];
  logic [N-1:0]     valid_vec;

  logic accept, visible, full;

  // --- configuration ---------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      screen_width  <= vods_pkg::SCREEN_WIDTH_RST;
      screen_height <= vods_pkg::SCREEN_HEIGHT_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        vods_pkg::REG_SCREEN_WIDTH:  screen_width  <= cfg_data;
        vods_pkg::REG_SCREEN_HEIGHT: screen_height <= cfg_data;
        default: ;
      endcase
    end
  end

  // --- screen cull: signed compares, screen size zero-extended -------------
  assign visible = (objects.rect_right > 16'sd0) &&
                   (objects.rect_bottom > 16'sd0) &&
                   ($signed({objects.rect_left[15], objects.rect_left}) <
                    $signed({5'b0, screen_width})) &&
                   ($signed({objects.rect_top[15], objects.rect_top}) <
                    $signed({5'b0, screen_height}));

  assign accept = objects.valid && objects.ready;
  assign full   = entries[N-1].valid;  // valid bits form a prefix

  // --- chain wiring: head sees a virtual valid, never-greater neighbor ------
  always_comb begin
    for (int i = 0; i < N; i++) begin
      if (i == 0) begin
        prev_entry[i] = '{valid: 1'b1, id: '0, key: '0};
        prev_gt[i]    = 1'b0;
      end else begin
        prev_entry[i] = entries[i-1];
        prev_gt[i]    = gt[i-1];
      end
      if (i == N-1) begin
        next_entry[i] = '{valid: 1'b0, id: '0, key: '0};
      end else begin
        next_entry[i] = entries[i+1];
      end
      valid_vec[i] = entries[i].valid;
    end
  end

  for (genvar g = 0; g < N; g++) begin : g_cell
    vods_cell u_cell (
      .clk        (clk),
      .rst        (rst),
      .ctl        (ctl),
      .new_id     (objects.object_id),
      .new_key    (objects.sort_key),
      .prev_entry (prev_entry[g]),
      .prev_gt    (prev_gt[g]),
      .next_entry (next_entry[g]),
      .entry      (entries[g]),
      .gt         (gt[g])
    );
  end

  // --- sequencer ---------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= vods_pkg::ST_LOAD;
      dropped <= 1'b0;
    end else begin
      state   <= state_next;
      dropped <= dropped_next;
    end
  end

  always_comb begin
    state_next     = state;
    dropped_next   = dropped;
    ctl            = '{insert: 1'b0, shift: 1'b0};
    objects.ready  = 1'b0;
    results.valid  = 1'b0;
    case (state)
      vods_pkg::ST_LOAD: begin
        objects.ready = 1'b1;
        if (accept && visible) begin
          if (full) dropped_next = 1'b1;
          else      ctl.insert   = 1'b1;
        end
        if (accept && objects.frame_end) state_next = vods_pkg::ST_DRAIN;
      end
      vods_pkg::ST_DRAIN: begin
        results.valid = entries[0].valid;
        ctl.shift     = entries[0].valid && results.ready;
        if (!entries[0].valid) begin
          // frame done (or empty): drop report ends with the frame
          dropped_next = 1'b0;
          state_next   = vods_pkg::ST_LOAD;
        end
      end
      default: state_next = vods_pkg::ST_LOAD;
    endcase
  end

  // results come straight from the head cell
  assign results.out_object_id = entries[0].id;
  assign results.out_sort_key  = entries[0].key;
  assign results.out_last      = !entries[1].valid;
  assign results.overflowed    = dropped;

  // --- checks ------------------------------------------------------------------
  `ASSERT_ALWAYS(a_valid_prefix, clk, rst, ((valid_vec >> 1) & ~valid_vec) == '0)
  `ASSERT_IMPLIES(a_no_overlap, clk, rst, objects.ready, !results.valid)
  `ASSERT_NEXT(a_last_empties, clk, rst,
               results.valid && results.ready && results.out_last, !entries[0].valid)
  `ASSERT_IMPLIES(a_no_insert_full, clk, rst, ctl.insert, !full && !ctl.shift)

endmodule

### verif/sorted_frame_monitor.sv
// ----------------------------------------------------------------------------
// sorted_frame_monitor
// Watches the object and result channels and the register port of the depth
// sorter. It culls and orders every accepted request the way the block should,
// queues the draw list of each frame at its end, and compares every accepted
// result with the oldest queued entry. It hands a failure count and the number
// of queued entries to the testbench top.
// ----------------------------------------------------------------------------
module sorted_frame_monitor (
  input  logic                            clk,
  input  logic                            rst,
  vods_obj_if                             objects,
  vods_res_if                             results,
  input  logic                            cfg_we,
  input  logic [vods_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [vods_pkg::CFG_DATA_W-1:0] cfg_data,
  output int unsigned                     pending,
  output int unsigned                     failures
);

  typedef struct {
    logic [vods_pkg::ID_W-1:0]         id;
    logic signed [vods_pkg::KEY_W-1:0] key;
  } held_obj_t;

  typedef struct {
    logic [vods_pkg::ID_W-1:0]         id;
    logic signed [vods_pkg::KEY_W-1:0] key;
    logic                              last;
    logic                              ovf;
  } draw_slot_t;

  held_obj_t                  depth_chain[$];  // kept objects of the open frame, key order
  draw_slot_t                 draw_list[$];    // results still owed by the block
  logic [vods_pkg::SCR_W-1:0] width_r  = vods_pkg::SCREEN_WIDTH_RST;
  logic [vods_pkg::SCR_W-1:0] height_r = vods_pkg::SCREEN_HEIGHT_RST;
  logic                       dropped  = 1'b0;
  int unsigned                fail_cnt = 0;

  // Signed compares against the zero-extended screen size.
  function automatic bit on_screen(int l, int r, int t, int b);
    return r > 0 && l < int'(width_r) && b > 0 && t < int'(height_r);
  endfunction

  // Goes after every held entry whose key is less than or equal to its own.
  task automatic place_object(held_obj_t obj);
    int pos;
    if (depth_chain.size() >= vods_pkg::MAX_OBJECTS) begin
      dropped = 1'b1;
    end else begin
      pos = depth_chain.size();
      while (pos > 0 && depth_chain[pos-1].key > obj.key) pos--;
      depth_chain.insert(pos, obj);
    end
  endtask

  task automatic close_frame();
    draw_slot_t slot;
    foreach (depth_chain[k]) begin
      slot.id   = depth_chain[k].id;
      slot.key  = depth_chain[k].key;
      slot.last = (k == depth_chain.size() - 1);
      slot.ovf  = dropped;
      draw_list = {draw_list, slot};
    end
    depth_chain.delete();
    dropped = 1'b0;
  endtask

  task automatic check_field(string name, logic [15:0] want, logic [15:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch: expected %h, actual %h", $time, name, want, got);
      fail_cnt++;
    end
  endtask

  always @(posedge clk) begin : watch
    draw_slot_t want;
    held_obj_t  obj;
    if (rst) begin
      depth_chain.delete();
      draw_list.delete();
      width_r  = vods_pkg::SCREEN_WIDTH_RST;
      height_r = vods_pkg::SCREEN_HEIGHT_RST;
      dropped  = 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          vods_pkg::REG_SCREEN_WIDTH:  width_r  = cfg_data;
          vods_pkg::REG_SCREEN_HEIGHT: height_r = cfg_data;
          default: ;
        endcase
      end
      if (results.valid && results.ready) begin
        if (draw_list.size() == 0) begin
          $display("%0t: unexpected result: expected none, actual id %h key %h",
                   $time, results.out_object_id, results.out_sort_key);
          fail_cnt++;
        end else begin
          want = draw_list.pop_front();
          check_field("out_object_id", want.id, results.out_object_id);
          check_field("out_sort_key", want.key, results.out_sort_key);
          check_field("out_last", 16'(want.last), 16'(results.out_last));
          check_field("overflowed", 16'(want.ovf), 16'(results.overflowed));
        end
      end
      if (objects.valid && objects.ready) begin
        if (on_screen(objects.rect_left, objects.rect_right,
                      objects.rect_top, objects.rect_bottom)) begin
          obj.id  = objects.object_id;
          obj.key = objects.sort_key;
          place_object(obj);
        end
        if (objects.frame_end) close_frame();
      end
    end
    pending  <= draw_list.size();
    failures <= fail_cnt;
  end

endmodule

### verif/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Stimulus and verdict for the visible object depth sorter.
// ----------------------------------------------------------------------------
// Object requests are sent in frames under several screen sizes: the reset
// size, the largest, one pixel, zero and random sizes. A short directed frame
// set hits the cull edges, the key extremes, equal keys, an empty frame and a
// culled frame end; then random frames follow, some of them past capacity.
// Sender and receiver stall at random, and once the receiver holds off long
// enough that a drain backs up into the request side. A separate monitor
// predicts and checks every result.
// ----------------------------------------------------------------------------
module testbench;

  localparam int CYCLE_LIMIT   = 400000;
  localparam int HOLD_CYCLES   = 400;   // long receiver hold-off
  localparam int SETTLE_CYCLES = 8;     // lets the drain hand back to loading after the last result
  localparam int MAX_GAP       = 40;    // cap on one sender gap

  logic                            clk;
  logic                            rst;
  logic                            cfg_we;
  logic [vods_pkg::CFG_IDX_W-1:0]  cfg_index;
  logic [vods_pkg::CFG_DATA_W-1:0] cfg_data;
  int unsigned                     pending;
  int unsigned                     failures;
  int unsigned                     cycle_cnt;
  int                    send_idle_pct;  // only the stimulus process uses it
  int                    recv_idle_pct;
  int                    hold_seq;       // bumped to ask for a long hold-off
  int                    width_now;      // screen size last programmed, for shaping
  int                    height_now;

  vods_obj_if objects ();
  vods_res_if results ();

  visible_object_depth_sorter DUT (
    .clk       (clk),
    .rst       (rst),
    .objects   (objects),
    .results   (results),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  sorted_frame_monitor order_check (
    .clk       (clk),
    .rst       (rst),
    .objects   (objects),
    .results   (results),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .pending   (pending),
    .failures  (failures)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Watchdog: a stuck handshake or a result that never comes ends up here.
  initial begin
    cycle_cnt = 0;
    while (cycle_cnt < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_cnt++;
    end
    $display("FAILURE");
    $finish;
  end

  // Result side: random ready, or held low for a counted stretch on request.
  initial begin : result_sink
    int hold_left;
    int seen_seq;
    hold_left = 0;
    seen_seq  = 0;
    results.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_seq != seen_seq) begin
        seen_seq  = hold_seq;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        results.ready <= 1'b0;
      end else begin
        results.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
    end
  end

  // --- edge value pickers: signed 16-bit bit patterns ---

  // Some value below bound, often right at the edge.
  function automatic logic [15:0] below(int bound);
    case ($urandom_range(0, 2))
      0:       return 16'(bound - 1);
      1:       return 16'(bound - 1 - int'($urandom_range(0, 3)));
      default: return 16'(int'($urandom_range(0, bound + 32767)) - 32768);
    endcase
  endfunction

  function automatic logic [15:0] not_below(int bound);
    if ($urandom_range(0, 1)) return 16'(bound);
    return 16'($urandom_range(bound, 32767));
  endfunction

  function automatic logic [15:0] above_zero();
    if ($urandom_range(0, 1)) return 16'd1;
    return 16'($urandom_range(1, 32767));
  endfunction

  function automatic logic [15:0] not_above_zero();
    if ($urandom_range(0, 1)) return 16'd0;
    return 16'(-int'($urandom_range(0, 32768)));
  endfunction

  // One object request; valid stays high when no gap is drawn, so back-to-back
  // requests never see valid dropped and raised in the same step.
  task automatic send_obj(logic [15:0] id, logic [15:0] key, logic [15:0] l,
                          logic [15:0] r, logic [15:0] t, logic [15:0] b,
                          logic fe);
    int gap;
    gap = 0;
    while ($urandom_range(0, 99) < send_idle_pct && gap < MAX_GAP) gap++;
    if (gap > 0) begin
      objects.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    objects.valid       <= 1'b1;
    objects.object_id   <= id;
    objects.sort_key    <= key;
    objects.rect_left   <= l;
    objects.rect_right  <= r;
    objects.rect_top    <= t;
    objects.rect_bottom <= b;
    objects.frame_end   <= fe;
    @(posedge clk);
    while (!objects.ready) @(posedge clk);
  endtask

  // Mostly on-screen requests, some with exactly one failing edge, some noise.
  task automatic send_random(logic fe);
    logic [15:0] key;
    logic [15:0] l, r, t, b;
    case ($urandom_range(0, 3))
      0, 1:    key = 16'($urandom);
      2:       key = 16'(3 - int'($urandom_range(0, 6)));  // many ties
      default: key = $urandom_range(0, 1) ? 16'h7FFF : 16'h8000;
    endcase
    l = below(width_now);
    r = above_zero();
    t = below(height_now);
    b = above_zero();
    case ($urandom_range(0, 9))
      0: l = not_below(width_now);
      1: r = not_above_zero();
      2: t = not_below(height_now);
      3: b = not_above_zero();
      4: begin
        l = 16'($urandom);
        r = 16'($urandom);
        t = 16'($urandom);
        b = 16'($urandom);
      end
      default: ;
    endcase
    send_obj(16'($urandom), key, l, r, t, b, fe);
  endtask

  // Frames until about count requests went out; every so often one that
  // overruns the chain.
  task automatic run_random(int count);
    int sent;
    int len;
    sent = 0;
    while (sent < count) begin
      len = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 40) : $urandom_range(1, 10);
      for (int i = 0; i < len; i++) send_random(i == len - 1);
      sent += len;
    end
  endtask

  // Registers change only with the block idle: valid low, every owed result
  // in, and SETTLE_CYCLES for the drain to hand back to loading.
  task automatic program_screen(int w, int h, int s_pct, int r_pct);
    objects.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    send_idle_pct  = s_pct;
    recv_idle_pct <= r_pct;
    width_now      = w;
    height_now     = h;
    cfg_we    <= 1'b1;
    cfg_index <= vods_pkg::REG_SCREEN_WIDTH;
    cfg_data  <= vods_pkg::CFG_DATA_W'(w);
    @(posedge clk);
    cfg_index <= vods_pkg::REG_SCREEN_HEIGHT;
    cfg_data  <= vods_pkg::CFG_DATA_W'(h);
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  initial begin : stimulus
    send_idle_pct = 34;
    recv_idle_pct <= 86;
    hold_seq      <= 0;
    width_now     = vods_pkg::SCREEN_WIDTH_RST;
    height_now    = vods_pkg::SCREEN_HEIGHT_RST;
    rst           <= 1'b1;
    cfg_we        <= 1'b0;
    cfg_index     <= vods_pkg::REG_SCREEN_WIDTH;
    cfg_data      <= '0;
    objects.valid       <= 1'b0;
    objects.object_id   <= '0;
    objects.sort_key    <= '0;
    objects.rect_left   <= '0;
    objects.rect_right  <= '0;
    objects.rect_top    <= '0;
    objects.rect_bottom <= '0;
    objects.frame_end   <= 1'b0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // Directed frames at the reset size of 800 x 600.
    // Smallest overlap, then the far edges and key extremes.
    send_obj(16'h0000, 16'h0000, 16'd0, 16'd1, 16'd0, 16'd1, 1'b0);
    send_obj(16'hFFFF, 16'h8000, 16'd799, 16'h7FFF, 16'd599, 16'h7FFF, 1'b0);
    send_obj(16'h0003, 16'h7FFF, 16'h8000, 16'd100, 16'h8000, 16'd100, 1'b0);
    // Each edge just off screen.
    send_obj(16'h0004, 16'h0005, 16'd10, 16'd0, 16'd10, 16'd20, 1'b0);
    send_obj(16'h0005, 16'h0005, 16'd800, 16'd900, 16'd10, 16'd20, 1'b0);
    send_obj(16'h0006, 16'h0005, 16'd10, 16'd20, 16'd10, 16'd0, 1'b0);
    send_obj(16'h0007, 16'h0005, 16'd10, 16'd20, 16'd600, 16'd700, 1'b0);
    send_obj(16'h0008, 16'h0005, 16'hFFF0, 16'hFFFF, 16'd10, 16'd20, 1'b0);
    // Equal keys must come out in arrival order.
    send_obj(16'h0009, 16'h0000, 16'd5, 16'd6, 16'd5, 16'd6, 1'b0);
    send_obj(16'h000A, 16'h0000, 16'd5, 16'd6, 16'd5, 16'd6, 1'b0);
    // Visible frame end is placed before the drain.
    send_obj(16'h5A5A, 16'hFFFF, 16'd1, 16'd2, 16'd1, 16'd2, 1'b1);
    // Empty frame: nothing at all comes back.
    send_obj(16'h000C, 16'h0001, 16'd900, 16'd950, 16'd10, 16'd20, 1'b1);
    // Single-object frame.
    send_obj(16'hA5A5, 16'h1234, 16'd400, 16'd401, 16'd300, 16'd301, 1'b1);
    // Culled frame end still closes the frame.
    send_obj(16'h0F0F, 16'h0010, 16'd0, 16'd1, 16'd0, 16'd1, 1'b0);
    send_obj(16'hF0F0, 16'h000F, 16'd0, 16'd1, 16'd0, 16'd1, 1'b0);
    send_obj(16'h00FF, 16'h0000, 16'd0, 16'd1, 16'd600, 16'd601, 1'b1);

    // Largest screen, receiver mostly stalled.
    program_screen(4095, 4095, 34, 86);
    run_random(40);

    // Now the sender is the slow side: one-pixel screen, then zero size where
    // only negative left and top edges pass.
    program_screen(1, 1, 86, 34);
    run_random(30);
    program_screen(0, 0, 86, 34);
    run_random(30);

    // No idling. The receiver holds off while an over-full frame goes in, so
    // the drain backs up into the request side.
    program_screen($urandom_range(1, 4095), $urandom_range(1, 4095), 0, 0);
    hold_seq <= hold_seq + 1;
    for (int i = 0; i < 35; i++) begin
      send_obj(16'($urandom), 16'($urandom), below(width_now), above_zero(),
               below(height_now), above_zero(), i == 34);
    end
    run_random(40);

    program_screen(vods_pkg::SCREEN_WIDTH_RST, vods_pkg::SCREEN_HEIGHT_RST, 0, 0);
    run_random(60);

    objects.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (4 * SETTLE_CYCLES) @(posedge clk);
    if (failures == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
